### rtl/core/sgb_pkg.sv
// package for the scaled glyph row blitter
// constants, register indexes and parameter defaults; depends on nothing
package sgb_pkg;

  // parameter defaults
  localparam int MAX_FONT_WIDTH_DEF = 16;
  localparam int MAX_SCALE_DEF      = 4;
  localparam int ADDR_BITS_DEF      = 32;

  // depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 8;

  // glyph row layout and fixed font limits
  localparam int GLYPH_BITS      = 16;
  localparam int GLYPH_TOP       = GLYPH_BITS - 1;
  localparam int MAX_FONT_HEIGHT = 32;
  localparam int MAX_BPP         = 4;

  // command codes
  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // configuration register reset values
  localparam logic [31:0] FRAME_BASE_RST  = 32'd0;
  localparam logic [15:0] PITCH_RST       = 16'd4096;
  localparam logic [2:0]  BPP_RST         = 3'd4;
  localparam logic [4:0]  FONT_WIDTH_RST  = 5'd8;
  localparam logic [5:0]  FONT_HEIGHT_RST = 6'd16;
  localparam logic [2:0]  FONT_SCALE_RST  = 3'd1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_BASE  = 3'd0,
    REG_PITCH       = 3'd1,
    REG_BPP         = 3'd2,
    REG_FONT_WIDTH  = 3'd3,
    REG_FONT_HEIGHT = 3'd4,
    REG_FONT_SCALE  = 3'd5
  } reg_index_t;

endpackage

### rtl/core/scaled_glyph_row_blitter.sv
// scaled glyph row blitter: each taken start passes the front part, the queue and
// the back part, then one pixel write per cycle, clamped font_width * font_scale writes per item
// a new item is taken every cycle while fewer than 8 are in flight, so the
// rate is set by the pixel walk in the back part; results cannot be stalled
// synchronous reset clears the registers to their defaults and drops all
// queued and in-flight items
module scaled_glyph_row_blitter #(
  parameter int MAX_FONT_WIDTH = sgb_pkg::MAX_FONT_WIDTH_DEF,
  parameter int MAX_SCALE      = sgb_pkg::MAX_SCALE_DEF,
  parameter int ADDR_BITS      = sgb_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  cell_col,
  input  logic [7:0]  cell_row,
  input  logic [6:0]  line,
  input  logic [15:0] glyph_bits,
  input  logic [31:0] fg,
  input  logic [31:0] bg,
  input  logic        underline,
  // result channel
  output logic        valid,
  output logic [31:0] byte_address,
  output logic [31:0] pixel_value,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sgb_pkg::*;

  localparam int SC_W   = $clog2(MAX_SCALE + 1);
  localparam int CW_W   = $clog2(MAX_FONT_WIDTH * MAX_SCALE + 1);
  localparam int DESC_W = 16 + 1 + 32 + 32 + ADDR_BITS + CW_W + SC_W + 3;
  localparam int IF_W   = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [31:0] frame_base;
  logic [15:0] pitch_bytes;
  logic [2:0]  pixel_stride;
  logic [4:0]  font_width;
  logic [5:0]  font_height;
  logic [2:0]  font_scale;
  reg_index_t  reg_idx;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_index_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base   <= FRAME_BASE_RST;
      pitch_bytes  <= PITCH_RST;
      pixel_stride <= BPP_RST;
      font_width   <= FONT_WIDTH_RST;
      font_height  <= FONT_HEIGHT_RST;
      font_scale   <= FONT_SCALE_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FRAME_BASE:  frame_base   <= pwdata;
        REG_PITCH:       pitch_bytes  <= pwdata[15:0];
        REG_BPP:         pixel_stride <= pwdata[2:0];
        REG_FONT_WIDTH:  font_width   <= pwdata[4:0];
        REG_FONT_HEIGHT: font_height  <= pwdata[5:0];
        REG_FONT_SCALE:  font_scale   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_BASE:  prdata = frame_base;
      REG_PITCH:       prdata = 32'(pitch_bytes);
      REG_BPP:         prdata = 32'(pixel_stride);
      REG_FONT_WIDTH:  prdata = 32'(font_width);
      REG_FONT_HEIGHT: prdata = 32'(font_height);
      REG_FONT_SCALE:  prdata = 32'(font_scale);
      default:         prdata = 32'd0;
    endcase
  end

  // in-flight count reserves a queue slot for every accepted transaction
  logic             accept;
  logic             pop;
  logic [IF_W-1:0]  inflight;

  assign accept = start && !busy;
  assign busy   = (inflight == IF_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !pop) begin
      inflight <= inflight + IF_W'(1);
    end else if (pop && !accept) begin
      inflight <= inflight - IF_W'(1);
    end
  end

  // front part
  logic              desc_valid;
  logic [DESC_W-1:0] desc;
  logic [DESC_W-1:0] head;
  logic              head_valid;

  sgb_front #(
    .MAX_FONT_WIDTH (MAX_FONT_WIDTH),
    .MAX_SCALE      (MAX_SCALE),
    .ADDR_BITS      (ADDR_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .cmd             (cmd),
    .cell_col        (cell_col),
    .cell_row        (cell_row),
    .line            (line),
    .glyph_bits      (glyph_bits),
    .fg              (fg),
    .bg              (bg),
    .underline       (underline),
    .frame_base      (frame_base),
    .pitch_bytes     (pitch_bytes),
    .pixel_stride    (pixel_stride),
    .font_width      (font_width),
    .font_height     (font_height),
    .font_scale      (font_scale),
    .desc_valid      (desc_valid),
    .desc            (desc)
  );

  // queue between front and back
  sgb_queue #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_valid),
    .wdata     (desc),
    .pop       (pop),
    .rdata     (head),
    .not_empty (head_valid)
  );

  // back part
  sgb_back #(
    .MAX_FONT_WIDTH (MAX_FONT_WIDTH),
    .MAX_SCALE      (MAX_SCALE),
    .ADDR_BITS      (ADDR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .valid        (valid),
    .byte_address (byte_address),
    .pixel_value  (pixel_value),
    .last         (last)
  );

endmodule

### rtl/core/sgb_queue.sv
// small first-in first-out queue of scanline transactions
// generic width and depth; depends on nothing
module sgb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata     = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

### rtl/core/sgb_front.sv
// front part: accepts scanline commands and works out the start address
// four register stages; depends on sgb_pkg
module sgb_front #(
  parameter int MAX_FONT_WIDTH = 16,
  parameter int MAX_SCALE      = 4,
  parameter int ADDR_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        cmd,
  input  logic [7:0]  cell_col,
  input  logic [7:0]  cell_row,
  input  logic [6:0]  line,
  input  logic [15:0] glyph_bits,
  input  logic [31:0] fg,
  input  logic [31:0] bg,
  input  logic        underline,
  input  logic [31:0] frame_base,
  input  logic [15:0] pitch_bytes,
  input  logic [2:0]  pixel_stride,
  input  logic [4:0]  font_width,
  input  logic [5:0]  font_height,
  input  logic [2:0]  font_scale,
  output logic        desc_valid,
  output logic [16+1+32+32+ADDR_BITS+$clog2(MAX_FONT_WIDTH*MAX_SCALE+1)
                +$clog2(MAX_SCALE+1)+3-1:0] desc
);
  import sgb_pkg::*;

  localparam int AW   = ADDR_BITS;
  localparam int FW_W = $clog2(MAX_FONT_WIDTH + 1);
  localparam int SC_W = $clog2(MAX_SCALE + 1);
  localparam int CW_W = $clog2(MAX_FONT_WIDTH * MAX_SCALE + 1);
  localparam int CH_W = $clog2(MAX_FONT_HEIGHT * MAX_SCALE + 1);
  localparam int UW   = (CH_W > 8) ? CH_W : 8;
  localparam int Y_W  = 8 + CH_W;
  localparam int PY_W = 16 + Y_W;
  localparam int CL_W = 8 + CW_W;
  localparam int CB_W = CL_W + 3;

  typedef struct packed {
    logic [15:0]      glyph;
    logic             under;
    logic [31:0]      fg;
    logic [31:0]      bg;
    logic [AW-1:0]    addr;
    logic [CW_W-1:0]  cw;
    logic [SC_W-1:0]  sc;
    logic [2:0]       bpp;
  } desc_t;

  // clamped geometry
  logic [FW_W-1:0] fw_c;
  logic [5:0]      fh_c;
  logic [SC_W-1:0] sc_c;
  logic [2:0]      bpp_c;

  always_comb begin
    if (font_width == 5'd0) begin
      fw_c = FW_W'(1);
    end else if (32'(font_width) > MAX_FONT_WIDTH) begin
      fw_c = FW_W'(MAX_FONT_WIDTH);
    end else begin
      fw_c = FW_W'(font_width);
    end
    if (font_height == 6'd0) begin
      fh_c = 6'd1;
    end else if (32'(font_height) > MAX_FONT_HEIGHT) begin
      fh_c = 6'(MAX_FONT_HEIGHT);
    end else begin
      fh_c = font_height;
    end
    if (font_scale == 3'd0) begin
      sc_c = SC_W'(1);
    end else if (32'(font_scale) > MAX_SCALE) begin
      sc_c = SC_W'(MAX_SCALE);
    end else begin
      sc_c = SC_W'(font_scale);
    end
    if (pixel_stride == 3'd0) begin
      bpp_c = 3'd1;
    end else if (32'(pixel_stride) > MAX_BPP) begin
      bpp_c = 3'(MAX_BPP);
    end else begin
      bpp_c = pixel_stride;
    end
  end

  // stage registers
  logic             s1_valid, s2_valid, s3_valid;
  logic [15:0]      s1_glyph, s2_glyph, s3_glyph;
  logic             s1_cmd, s1_ul;
  logic             s2_under, s3_under;
  logic [6:0]       s1_line;
  logic [7:0]       s1_col, s1_row;
  logic [31:0]      s1_fg, s2_fg, s3_fg;
  logic [31:0]      s1_bg, s2_bg, s3_bg;
  logic [CH_W-1:0]  s1_ch;
  logic [CW_W-1:0]  s1_cw, s2_cw, s3_cw;
  logic [SC_W-1:0]  s1_sc, s2_sc, s3_sc;
  logic [2:0]       s1_bpp, s2_bpp, s3_bpp;
  logic [Y_W-1:0]   s2_y;
  logic [CL_W-1:0]  s2_colw;
  logic [PY_W-1:0]  s3_py;
  logic [CB_W-1:0]  s3_colb;
  desc_t            s4;

  // valid bits through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      desc_valid <= 1'b0;
    end else begin
      s1_valid   <= accept;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      desc_valid <= s3_valid;
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    // stage 1: capture, clear folds into an empty glyph, cell size
    s1_glyph <= (cmd == CMD_CLEAR) ? 16'd0 : glyph_bits;
    s1_cmd   <= cmd;
    s1_ul    <= underline;
    s1_line  <= line;
    s1_col   <= cell_col;
    s1_row   <= cell_row;
    s1_fg    <= fg;
    s1_bg    <= bg;
    s1_ch    <= CH_W'(fh_c) * CH_W'(sc_c);
    s1_cw    <= CW_W'(fw_c) * CW_W'(sc_c);
    s1_sc    <= sc_c;
    s1_bpp   <= bpp_c;

    // stage 2: screen scanline, cell start column, underline test
    s2_glyph <= s1_glyph;
    s2_under <= (s1_cmd == CMD_DRAW) && s1_ul &&
                ((UW'(s1_line) + UW'(1)) == UW'(s1_ch));
    s2_fg    <= s1_fg;
    s2_bg    <= s1_bg;
    s2_y     <= Y_W'(s1_row) * Y_W'(s1_ch) + Y_W'(s1_line);
    s2_colw  <= CL_W'(s1_col) * CL_W'(s1_cw);
    s2_cw    <= s1_cw;
    s2_sc    <= s1_sc;
    s2_bpp   <= s1_bpp;

    // stage 3: scanline offset and column offset in bytes
    s3_glyph <= s2_glyph;
    s3_under <= s2_under;
    s3_fg    <= s2_fg;
    s3_bg    <= s2_bg;
    s3_py    <= PY_W'(pitch_bytes) * PY_W'(s2_y);
    s3_colb  <= CB_W'(s2_colw) * CB_W'(s2_bpp);
    s3_cw    <= s2_cw;
    s3_sc    <= s2_sc;
    s3_bpp   <= s2_bpp;

    // stage 4: first pixel address, wrapped to the address width
    s4.glyph <= s3_glyph;
    s4.under <= s3_under;
    s4.fg    <= s3_fg;
    s4.bg    <= s3_bg;
    s4.addr  <= AW'(frame_base) + AW'(s3_py) + AW'(s3_colb);
    s4.cw    <= s3_cw;
    s4.sc    <= s3_sc;
    s4.bpp   <= s3_bpp;
  end

  assign desc = s4;

endmodule

### rtl/core/sgb_back.sv
// back part: walks one queued scanline and emits one pixel write a cycle
// registered result outputs, combinational pop; depends on sgb_pkg
module sgb_back #(
  parameter int MAX_FONT_WIDTH = 16,
  parameter int MAX_SCALE      = 4,
  parameter int ADDR_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  logic [16+1+32+32+ADDR_BITS+$clog2(MAX_FONT_WIDTH*MAX_SCALE+1)
                +$clog2(MAX_SCALE+1)+3-1:0] head,
  output logic        pop,
  output logic        valid,
  output logic [31:0] byte_address,
  output logic [31:0] pixel_value,
  output logic        last
);
  import sgb_pkg::*;

  localparam int AW   = ADDR_BITS;
  localparam int SC_W = $clog2(MAX_SCALE + 1);
  localparam int CW_W = $clog2(MAX_FONT_WIDTH * MAX_SCALE + 1);
  localparam int OW   = (AW > 32) ? AW : 32;

  typedef struct packed {
    logic [15:0]      glyph;
    logic             under;
    logic [31:0]      fg;
    logic [31:0]      bg;
    logic [AW-1:0]    addr;
    logic [CW_W-1:0]  cw;
    logic [SC_W-1:0]  sc;
    logic [2:0]       bpp;
  } desc_t;

  desc_t            hd;
  logic             active;
  logic [15:0]      glyph_sh;
  logic             under;
  logic [31:0]      fg_r, bg_r;
  logic [AW-1:0]    addr;
  logic [CW_W-1:0]  rem;
  logic [SC_W-1:0]  sc;
  logic [SC_W-1:0]  sub;
  logic [2:0]       bpp;
  logic             at_last;
  logic             sub_wrap;
  logic [OW-1:0]    addr_wide;

  assign hd        = head;
  assign at_last   = (rem == CW_W'(1));
  assign sub_wrap  = (SC_W'(sub + SC_W'(1)) == sc);
  assign pop       = head_valid && (!active || at_last);
  assign addr_wide = OW'(addr);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      valid  <= 1'b0;
    end else begin
      valid  <= active;
      active <= pop || (active && !at_last);
    end
  end

  // per-pixel walk and output registers
  always_ff @(posedge clk) begin
    if (active) begin
      byte_address <= addr_wide[31:0];
      pixel_value  <= (glyph_sh[GLYPH_TOP] || under) ? fg_r : bg_r;
      last         <= at_last;
    end
    if (pop) begin
      glyph_sh <= hd.glyph;
      under    <= hd.under;
      fg_r     <= hd.fg;
      bg_r     <= hd.bg;
      addr     <= hd.addr;
      rem      <= hd.cw;
      sc       <= hd.sc;
      sub      <= '0;
      bpp      <= hd.bpp;
    end else if (active) begin
      rem  <= rem - CW_W'(1);
      addr <= addr + AW'(bpp);
      if (sub_wrap) begin
        sub      <= '0;
        glyph_sh <= {glyph_sh[14:0], 1'b0};
      end else begin
        sub <= sub + SC_W'(1);
      end
    end
  end

endmodule
